>>> rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes and constants shared by the priority thread scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_THREADS_DEF = 16;
   localparam int TID_W           = 4;
   localparam int PRI_W           = 8;
   localparam int OPCODE_W        = 3;
   localparam int ERR_W           = 2;
   localparam int COUNT_W         = 5;

   localparam logic [OPCODE_W-1:0] OP_MAKE_READY = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PREEMPT    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_BLOCK      = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_YIELD      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SET_PRI    = 3'd4;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [TID_W-1:0]        thread_id;
      logic signed [PRI_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [TID_W-1:0]        running_thread;
      logic signed [PRI_W-1:0] running_priority;
      logic                    switched;
      logic                    wake_hint;
      logic [ERR_W-1:0]        error_code;
      logic [COUNT_W-1:0]      ready_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REQUEUE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             latch;
      logic             insert_req;
      logic             insert_saved;
      logic             pop;
      logic             set_flags;
      logic [ERR_W-1:0] err;
      logic             switched;
      logic             hint_en;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                empty;
      logic                full;
      logic                head_due;
   } status_type;

endpackage

>>> rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath
// Sorted ready chain, running thread registers and result registers.
// ----------------------------------------------------------------------------
module pts_datapath
   import pts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_item
);

   localparam int LEN_W = $clog2(MAX_THREADS + 1);

   logic [TID_W-1:0]        ids_ff  [MAX_THREADS];
   logic [TID_W-1:0]        ids_in  [MAX_THREADS];
   logic signed [PRI_W-1:0] pris_ff [MAX_THREADS];
   logic signed [PRI_W-1:0] pris_in [MAX_THREADS];
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [TID_W-1:0]        cur_id_ff, cur_id_in;
   logic signed [PRI_W-1:0] cur_pri_ff, cur_pri_in;
   logic [TID_W-1:0]        sav_id_ff, sav_id_in;
   logic signed [PRI_W-1:0] sav_pri_ff, sav_pri_in;
   req_type                 req_ff, req_in;
   logic                    switched_ff, switched_in;
   logic                    hint_ff, hint_in;
   logic [ERR_W-1:0]        err_ff, err_in;

   logic [MAX_THREADS-1:0]  ge;
   logic [TID_W-1:0]        ins_id;
   logic signed [PRI_W-1:0] ins_pri;
   logic                    do_insert;

   assign do_insert = cmd.insert_req | cmd.insert_saved;
   assign ins_id    = cmd.insert_saved ? sav_id_ff  : req_ff.thread_id;
   assign ins_pri   = cmd.insert_saved ? sav_pri_ff : req_ff.priority_req;

   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         ge[i] = (LEN_W'(i) < len_ff) && (pris_ff[i] >= ins_pri);
      end
   end

   always_comb begin
      ids_in      = ids_ff;
      pris_in     = pris_ff;
      len_in      = len_ff;
      cur_id_in   = cur_id_ff;
      cur_pri_in  = cur_pri_ff;
      sav_id_in   = sav_id_ff;
      sav_pri_in  = sav_pri_ff;
      req_in      = req_ff;
      switched_in = switched_ff;
      hint_in     = hint_ff;
      err_in      = err_ff;
      if (cmd.latch) begin
         req_in      = req_item;
         switched_in = 1'b0;
         hint_in     = 1'b0;
         err_in      = ERR_OK;
         if (req_item.opcode == OP_SET_PRI) begin
            cur_pri_in = req_item.priority_req;
         end
      end
      if (cmd.set_flags) begin
         err_in      = cmd.err;
         switched_in = cmd.switched;
         hint_in     = cmd.hint_en && (req_ff.priority_req >= cur_pri_ff);
      end
      if (do_insert) begin
         if (!ge[0]) begin
            ids_in[0]  = ins_id;
            pris_in[0] = ins_pri;
         end
         for (int i = 1; i < MAX_THREADS; i++) begin
            if (!ge[i]) begin
               if (ge[i-1]) begin
                  ids_in[i]  = ins_id;
                  pris_in[i] = ins_pri;
               end else begin
                  ids_in[i]  = ids_ff[i-1];
                  pris_in[i] = pris_ff[i-1];
               end
            end
         end
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.pop) begin
         for (int i = 0; i < MAX_THREADS - 1; i++) begin
            ids_in[i]  = ids_ff[i+1];
            pris_in[i] = pris_ff[i+1];
         end
         cur_id_in  = ids_ff[0];
         cur_pri_in = pris_ff[0];
         sav_id_in  = cur_id_ff;
         sav_pri_in = cur_pri_ff;
         len_in     = len_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      ids_ff      <= ids_in;
      pris_ff     <= pris_in;
      sav_id_ff   <= sav_id_in;
      sav_pri_ff  <= sav_pri_in;
      req_ff      <= req_in;
      switched_ff <= switched_in;
      hint_ff     <= hint_in;
      err_ff      <= err_in;
      if (reset) begin
         len_ff     <= '0;
         cur_id_ff  <= '0;
         cur_pri_ff <= '0;
      end else begin
         len_ff     <= len_in;
         cur_id_ff  <= cur_id_in;
         cur_pri_ff <= cur_pri_in;
      end
   end

   assign status.opcode   = req_ff.opcode;
   assign status.empty    = (len_ff == '0);
   assign status.full     = (len_ff == LEN_W'(MAX_THREADS));
   assign status.head_due = !status.empty && (pris_ff[0] >= cur_pri_ff);

   assign rsp_item.running_thread   = cur_id_ff;
   assign rsp_item.running_priority = cur_pri_ff;
   assign rsp_item.switched         = switched_ff;
   assign rsp_item.wake_hint        = hint_ff;
   assign rsp_item.error_code       = err_ff;
   assign rsp_item.ready_count      = COUNT_W'(len_ff);

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_THREADS))
      else $error("ready chain length out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.empty)
      else $error("pop from empty ready chain");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      do_insert |-> !status.full)
      else $error("insert into full ready chain");

endmodule

>>> rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: decodes the opcode and steps the datapath through each beat.
// ----------------------------------------------------------------------------
module pts_ctrl
   import pts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.err    = ERR_OK;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.set_flags = 1'b1;
            state_in      = ST_RESP;
            unique case (status.opcode)
               OP_MAKE_READY: begin
                  if (status.full) begin
                     cmd.err = ERR_FULL;
                  end else begin
                     cmd.insert_req = 1'b1;
                     cmd.hint_en    = 1'b1;
                  end
               end
               OP_PREEMPT, OP_YIELD, OP_SET_PRI: begin
                  if (status.head_due) begin
                     cmd.pop      = 1'b1;
                     cmd.switched = 1'b1;
                     state_in     = ST_REQUEUE;
                  end
               end
               OP_BLOCK: begin
                  if (status.empty) begin
                     cmd.err = ERR_EMPTY;
                  end else begin
                     cmd.pop      = 1'b1;
                     cmd.switched = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_REQUEUE: begin
            cmd.insert_saved = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   a_requeue_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REQUEUE) |-> $past(cmd.pop))
      else $error("requeue without a preceding pop");

endmodule

>>> rtl/priority_thread_scheduler.sv
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// Ready queue and dispatcher for a fixed-priority preemptive kernel.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy then stays
// high until the result beat has been shown. The result appears on rsp_item
// for a single cycle with rsp_strobe high and must be captured then, since
// the receiver cannot stall it. The request is latched when accepted, then
// executed, then shown; a preempt, yield or priority change that swaps
// threads adds a requeue step before the result is shown. The extra step
// comes from the sorted ready chain, which does one shift per cycle: the pop
// of the head and the requeue of the old running thread are two separate
// chain updates. The next request is taken in the cycle after the strobe.
// ----------------------------------------------------------------------------
module priority_thread_scheduler
   import pts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pts_datapath #(
      .MAX_THREADS (MAX_THREADS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

>>> sim/priority_thread_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_thread_scheduler_tb
// Self-checking bench for the ready queue and dispatcher. A behavioral model
// of the sorted ready queue and the running thread predicts every result beat,
// which is compared field by field as it leaves the block. Directed beats
// cover every opcode, priority extremes, FIFO order among equal priorities,
// the full and empty errors; random phases then drive the queue between
// empty and full with and without idle gaps on the request side.
// ----------------------------------------------------------------------------
module priority_thread_scheduler_tb;
   import pts_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam logic signed [PRI_W-1:0] PRI_TOP    = 8'sh7f;
   localparam logic signed [PRI_W-1:0] PRI_BOTTOM = 8'sh80;
   localparam int QUEUE_DEPTH = MAX_THREADS_DEF;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_item   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   priority_thread_scheduler #(
      .MAX_THREADS(QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler model
   logic [TID_W-1:0]        ready_ids  [QUEUE_DEPTH];
   logic signed [PRI_W-1:0] ready_pris [QUEUE_DEPTH];
   int                      ready_len = 0;
   logic [TID_W-1:0]        run_id    = '0;
   logic signed [PRI_W-1:0] run_pri   = '0;

   rsp_type pending_rsp[$];
   int      fail_count = 0;

   // new entry goes behind every entry of greater or equal priority
   function automatic void ready_insert(input logic [TID_W-1:0] id,
                                        input logic signed [PRI_W-1:0] pri);
      int pos;
      pos = 0;
      while (pos < ready_len && ready_pris[pos] >= pri) pos++;
      for (int i = ready_len; i > pos; i--) begin
         ready_ids[i]  = ready_ids[i-1];
         ready_pris[i] = ready_pris[i-1];
      end
      ready_ids[pos]  = id;
      ready_pris[pos] = pri;
      ready_len++;
   endfunction

   function automatic void ready_pop_to_run();
      run_id  = ready_ids[0];
      run_pri = ready_pris[0];
      for (int i = 1; i < ready_len; i++) begin
         ready_ids[i-1]  = ready_ids[i];
         ready_pris[i-1] = ready_pris[i];
      end
      ready_len--;
   endfunction

   function automatic logic swap_if_due();
      logic [TID_W-1:0]        old_id;
      logic signed [PRI_W-1:0] old_pri;
      if (ready_len == 0 || ready_pris[0] < run_pri) return 1'b0;
      old_id  = run_id;
      old_pri = run_pri;
      ready_pop_to_run();
      ready_insert(old_id, old_pri);
      return 1'b1;
   endfunction

   function automatic rsp_type sched_predict(input req_type r);
      rsp_type                 res;
      logic signed [PRI_W-1:0] pri;
      res = '0;
      res.error_code = ERR_OK;
      pri = r.priority_req;
      case (r.opcode)
         OP_MAKE_READY: begin
            if (ready_len >= QUEUE_DEPTH) begin
               res.error_code = ERR_FULL;
            end else begin
               ready_insert(r.thread_id, pri);
               res.wake_hint = (pri >= run_pri);
            end
         end
         OP_PREEMPT, OP_YIELD: begin
            res.switched = swap_if_due();
         end
         OP_BLOCK: begin
            if (ready_len == 0) begin
               res.error_code = ERR_EMPTY;
            end else begin
               ready_pop_to_run();
               res.switched = 1'b1;
            end
         end
         OP_SET_PRI: begin
            run_pri = pri;
            res.switched = swap_if_due();
         end
         default: ;
      endcase
      res.running_thread   = run_id;
      res.running_priority = run_pri;
      res.ready_count      = COUNT_W'(ready_len);
      return res;
   endfunction

   function automatic req_type make_beat(input logic [OPCODE_W-1:0] op,
                                         input int tid,
                                         input logic signed [PRI_W-1:0] pri);
      req_type r;
      r.opcode       = op;
      r.thread_id    = TID_W'(tid);
      r.priority_req = pri;
      return r;
   endfunction

   function automatic logic signed [PRI_W-1:0] random_pri();
      case ($urandom_range(3))
         0:       return PRI_W'($urandom_range(0, 255));
         3:       return $urandom_range(1) ? PRI_TOP : PRI_BOTTOM;
         default: return PRI_W'(int'($urandom_range(0, 4)) - 2);
      endcase
   endfunction

   function automatic req_type random_beat(input int fill_pct);
      req_type r;
      int      roll;
      r.thread_id    = TID_W'($urandom_range(0, 15));
      r.priority_req = random_pri();
      if ($urandom_range(99) < fill_pct) begin
         r.opcode = OP_MAKE_READY;
      end else begin
         roll = $urandom_range(0, 20);
         if (roll < 5)       r.opcode = OP_PREEMPT;
         else if (roll < 10) r.opcode = OP_BLOCK;
         else if (roll < 15) r.opcode = OP_YIELD;
         else if (roll < 19) r.opcode = OP_SET_PRI;
         else r.opcode = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      return r;
   endfunction

   // start stays high after acceptance; only idle_cycles lowers it
   task automatic send_beat(input req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(sched_predict(r));
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic test_opcodes();
      send_beat(make_beat(OP_BLOCK, 0, 8'sd0));
      send_beat(make_beat(OP_YIELD, 0, 8'sd0));
      send_beat(make_beat(OP_MAKE_READY, 15, PRI_TOP));
      send_beat(make_beat(OP_MAKE_READY, 0, PRI_BOTTOM));
      send_beat(make_beat(OP_MAKE_READY, 5, PRI_TOP));
      send_beat(make_beat(OP_PREEMPT, 0, 8'sd0));
      send_beat(make_beat(OP_YIELD, 0, 8'sd0));
      send_beat(make_beat(OP_SET_PRI, 0, PRI_BOTTOM));
      send_beat(make_beat(OP_SET_PRI, 0, PRI_TOP));
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         send_beat(make_beat(OPCODE_W'(op), $urandom_range(0, 15), random_pri()));
      end
      send_beat(make_beat(OP_BLOCK, 0, 8'sd0));
      send_beat(make_beat(OP_PREEMPT, 0, 8'sd0));
   endtask

   task automatic test_queue_full();
      while (ready_len < QUEUE_DEPTH) begin
         send_beat(make_beat(OP_MAKE_READY, $urandom_range(0, 15), random_pri()));
      end
      send_beat(make_beat(OP_MAKE_READY, 9, PRI_TOP));
   endtask

   task automatic test_random(input int beats, input int idle_pct);
      int fill_pct;
      fill_pct = 35;
      for (int i = 0; i < beats; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(2))
               0:       fill_pct = 15;
               1:       fill_pct = 35;
               default: fill_pct = 55;
            endcase
         end
         if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 5));
         send_beat(random_beat(fill_pct));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat %p", rsp_item);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.running_thread !== want.running_thread) begin
               $error("running_thread: expected %0d, got %0d",
                      want.running_thread, rsp_item.running_thread);
               fail_count++;
            end
            if (rsp_item.running_priority !== want.running_priority) begin
               $error("running_priority: expected %0d, got %0d",
                      want.running_priority, rsp_item.running_priority);
               fail_count++;
            end
            if (rsp_item.switched !== want.switched) begin
               $error("switched: expected %0d, got %0d",
                      want.switched, rsp_item.switched);
               fail_count++;
            end
            if (rsp_item.wake_hint !== want.wake_hint) begin
               $error("wake_hint: expected %0d, got %0d",
                      want.wake_hint, rsp_item.wake_hint);
               fail_count++;
            end
            if (rsp_item.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d",
                      want.error_code, rsp_item.error_code);
               fail_count++;
            end
            if (rsp_item.ready_count !== want.ready_count) begin
               $error("ready_count: expected %0d, got %0d",
                      want.ready_count, rsp_item.ready_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_opcodes();
      test_queue_full();
      test_random(700, 0);
      test_random(700, 59);
      test_random(700, 22);
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
